### rtl/cce_pkg.sv
// ----------------------------------------------------------------------------
// cce_pkg
// shared types, register codes and bit transpose / crc round functions
// ----------------------------------------------------------------------------
package cce_pkg;

   localparam int unsigned WORD_W          = 32;
   localparam int unsigned ADDR_W          = 5;
   localparam int unsigned STEPS_PER_ROUND = 8;
   localparam int unsigned QUEUE_DEPTH     = 2;   // power of two
   localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W          = QPTR_W + 1;
   localparam int unsigned ROUND_W         = $clog2(WORD_W / STEPS_PER_ROUND);

   localparam logic [ROUND_W-1:0] LAST_ROUND_16 = ROUND_W'(16 / STEPS_PER_ROUND - 1);
   localparam logic [ROUND_W-1:0] LAST_ROUND_32 = ROUND_W'(32 / STEPS_PER_ROUND - 1);

   // register indexes, byte address is 4 * index
   localparam logic [2:0] REG_WIDTH = 3'd0;
   localparam logic [2:0] REG_SEED  = 3'd1;
   localparam logic [2:0] REG_POLY  = 3'd2;
   localparam logic [2:0] REG_WSWAP = 3'd3;
   localparam logic [2:0] REG_RSWAP = 3'd4;
   localparam logic [2:0] REG_XOR   = 3'd5;

   // transpose modes
   localparam logic [1:0] SWAP_NONE  = 2'd0;
   localparam logic [1:0] SWAP_BITS  = 2'd1;
   localparam logic [1:0] SWAP_ALL   = 2'd2;
   localparam logic [1:0] SWAP_BYTES = 2'd3;

   localparam logic [WORD_W-1:0] MASK16 = 32'h0000_FFFF;
   localparam logic [WORD_W-1:0] MASK32 = 32'hFFFF_FFFF;

   typedef logic [WORD_W-1:0] word_type;

   // configuration seen by the crc engine
   typedef struct packed {
      logic       is32;
      word_type   poly;
      word_type   final_xor;
      logic [1:0] rd_mode;
      logic       seed_load;
      word_type   seed_word;
   } cfg_type;

   function automatic word_type rev_bits_in_bytes(input word_type v);
      word_type r;
      for (int i = 0; i < WORD_W; i++) begin
         r[(i / 8) * 8 + (7 - (i % 8))] = v[i];
      end
      return r;
   endfunction

   function automatic word_type rev_bytes(input word_type v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   function automatic word_type transpose(input word_type v, input logic [1:0] mode);
      word_type r;
      unique case (mode)
         SWAP_NONE:  r = v;
         SWAP_BITS:  r = rev_bits_in_bytes(v);
         SWAP_ALL:   r = rev_bytes(rev_bits_in_bytes(v));
         SWAP_BYTES: r = rev_bytes(v);
         default:    r = v;
      endcase
      return r;
   endfunction

   // eight msb-first shift / xor steps, feedback from bit 15 or bit 31
   function automatic word_type crc_round(input word_type value, input word_type poly,
                                          input logic is32);
      word_type c;
      logic     fb;
      c = value;
      for (int i = 0; i < STEPS_PER_ROUND; i++) begin
         fb = is32 ? c[WORD_W-1] : c[15];
         c  = {c[WORD_W-2:0], 1'b0} ^ (poly & {WORD_W{fb}});
      end
      return c;
   endfunction

endpackage

### rtl/cce_csr.sv
// ----------------------------------------------------------------------------
// cce_csr
// apb register file, seed write produces a running crc reload
// ----------------------------------------------------------------------------
module cce_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [cce_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [cce_pkg::WORD_W-1:0]  csr_pwdata,
   output logic [cce_pkg::WORD_W-1:0]  csr_prdata,
   output cce_pkg::cfg_type            cfg,
   output logic [1:0]                  wr_mode
);

   logic                 width_ff, width_in;
   cce_pkg::word_type    seed_ff, seed_in;
   cce_pkg::word_type    poly_ff, poly_in;
   logic [1:0]           wswap_ff, wswap_in;
   logic [1:0]           rswap_ff, rswap_in;
   cce_pkg::word_type    xor_ff, xor_in;
   logic                 wr_en;
   logic [2:0]           reg_idx;

   assign reg_idx = csr_paddr[4:2];
   assign wr_en   = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      width_in = width_ff;
      seed_in  = seed_ff;
      poly_in  = poly_ff;
      wswap_in = wswap_ff;
      rswap_in = rswap_ff;
      xor_in   = xor_ff;
      if (wr_en) begin
         unique case (reg_idx)
            cce_pkg::REG_WIDTH: width_in = csr_pwdata[0];
            cce_pkg::REG_SEED:  seed_in  = csr_pwdata;
            cce_pkg::REG_POLY:  poly_in  = csr_pwdata;
            cce_pkg::REG_WSWAP: wswap_in = csr_pwdata[1:0];
            cce_pkg::REG_RSWAP: rswap_in = csr_pwdata[1:0];
            cce_pkg::REG_XOR:   xor_in   = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 1'b0;
         seed_ff  <= '0;
         poly_ff  <= '0;
         wswap_ff <= cce_pkg::SWAP_NONE;
         rswap_ff <= cce_pkg::SWAP_NONE;
         xor_ff   <= '0;
      end else begin
         width_ff <= width_in;
         seed_ff  <= seed_in;
         poly_ff  <= poly_in;
         wswap_ff <= wswap_in;
         rswap_ff <= rswap_in;
         xor_ff   <= xor_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         cce_pkg::REG_WIDTH: csr_prdata = {31'd0, width_ff};
         cce_pkg::REG_SEED:  csr_prdata = seed_ff;
         cce_pkg::REG_POLY:  csr_prdata = poly_ff;
         cce_pkg::REG_WSWAP: csr_prdata = {30'd0, wswap_ff};
         cce_pkg::REG_RSWAP: csr_prdata = {30'd0, rswap_ff};
         cce_pkg::REG_XOR:   csr_prdata = xor_ff;
         default:            csr_prdata = '0;
      endcase
   end

   // seed reload uses the write transpose in force at the time of the write
   assign cfg.is32      = width_ff;
   assign cfg.poly      = poly_ff;
   assign cfg.final_xor = xor_ff;
   assign cfg.rd_mode   = rswap_ff;
   assign cfg.seed_load = wr_en && (reg_idx == cce_pkg::REG_SEED);
   assign cfg.seed_word = cce_pkg::transpose(csr_pwdata, wswap_ff);
   assign wr_mode       = wswap_ff;

endmodule

### rtl/cce_front.sv
// ----------------------------------------------------------------------------
// cce_front
// input side: takes data words and write-transposes them into the queue
// ----------------------------------------------------------------------------
module cce_front (
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [cce_pkg::WORD_W-1:0]  req_tdata,
   input  logic [1:0]                  wr_mode,
   input  logic                        q_full,
   output logic                        push,
   output cce_pkg::word_type           push_data
);

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;
   assign push_data  = cce_pkg::transpose(req_tdata, wr_mode);

endmodule

### rtl/cce_queue.sv
// ----------------------------------------------------------------------------
// cce_queue
// short fifo between front and crc engine
// ----------------------------------------------------------------------------
module cce_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cce_pkg::word_type   push_data,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output cce_pkg::word_type   head_data
);

   cce_pkg::word_type                 slot_ff [cce_pkg::QUEUE_DEPTH];
   logic [cce_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [cce_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [cce_pkg::QCNT_W-1:0]        count_ff, count_in;

   assign full       = (count_ff == cce_pkg::QCNT_W'(cce_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/cce_back.sv
// ----------------------------------------------------------------------------
// cce_back
// crc engine: iterative 8-step rounds, running crc and result register
// ----------------------------------------------------------------------------
module cce_back (
   input  logic                        clock,
   input  logic                        reset,
   input  cce_pkg::cfg_type            cfg,
   input  logic                        q_valid,
   input  cce_pkg::word_type           q_data,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [cce_pkg::WORD_W-1:0]  rsp_tdata
);

   logic                            busy_ff, busy_in;
   logic [cce_pkg::ROUND_W-1:0]     round_ff, round_in;
   cce_pkg::word_type               work_ff, work_in;
   cce_pkg::word_type               running_ff, running_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   cce_pkg::word_type               rsp_data_ff, rsp_data_in;

   cce_pkg::word_type               round_src;
   cce_pkg::word_type               stepped;
   cce_pkg::word_type               width_mask;
   cce_pkg::word_type               result;
   logic                            last_round;
   logic                            out_free;
   logic                            advance;
   logic                            finish;

   // first round folds the new word into the running crc
   assign round_src  = busy_ff ? work_ff : (running_ff ^ q_data);
   assign stepped    = cce_pkg::crc_round(round_src, cfg.poly, cfg.is32);
   assign width_mask = cfg.is32 ? cce_pkg::MASK32 : cce_pkg::MASK16;
   assign result     = stepped & width_mask;
   assign last_round = cfg.is32 ? (round_ff == cce_pkg::LAST_ROUND_32)
                                : (round_ff == cce_pkg::LAST_ROUND_16);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = (busy_ff || q_valid) && (!last_round || out_free);
   assign finish     = advance && last_round;
   assign q_pop      = advance && !busy_ff;

   always_comb begin
      busy_in      = busy_ff;
      round_in     = round_ff;
      work_in      = work_ff;
      running_in   = running_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (finish) begin
         busy_in      = 1'b0;
         round_in     = '0;
         running_in   = result;
         rsp_valid_in = 1'b1;
         rsp_data_in  = cce_pkg::transpose((result ^ cfg.final_xor) & width_mask,
                                           cfg.rd_mode);
      end else if (advance) begin
         busy_in  = 1'b1;
         round_in = round_ff + 1'b1;
         work_in  = stepped;
      end
      if (cfg.seed_load) begin
         running_in = cfg.seed_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         round_ff     <= '0;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         round_ff     <= round_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/configurable_crc_engine_core.sv
// ----------------------------------------------------------------------------
// configurable_crc_engine_core
// programmable crc-16 / crc-32 unit with input and output bit/byte transpose
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  req_      in         req_tvalid/req_tready  req_tdata[31:0] = data_word
//  rsp_      out        rsp_tvalid/rsp_tready  rsp_tdata[31:0] = crc_result
//  csr_      in (apb)   psel/penable/pready    six registers at 4*index
//
//  a word runs through the crc engine in rounds of one shared 8-step shift/xor
//  round unit, up to LAST_ROUND_16 in 16-bit mode or LAST_ROUND_32 in 32-bit
//  mode, one round a cycle unless the last round waits for the result register;
//  a new word is taken only after the last round of the one before, and the
//  result is registered on rsp_tvalid/rsp_tdata; reset is synchronous and clears
//  the configuration, the running crc and all valid flags
//  a two-entry queue takes words while the engine works; req_tready drops once
//  both entries are taken, and the last round waits while the result register
//  is held by rsp_tready
//
module configurable_crc_engine_core (
   input  logic                        clock,
   input  logic                        reset,
   // input stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [cce_pkg::WORD_W-1:0]  req_tdata,    // [31:0] data_word
   // result stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [cce_pkg::WORD_W-1:0]  rsp_tdata,    // [31:0] crc_result
   // register port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [cce_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [cce_pkg::WORD_W-1:0]  csr_pwdata,
   output logic [cce_pkg::WORD_W-1:0]  csr_prdata,
   output logic                        csr_pready
);

   cce_pkg::cfg_type    cfg;
   logic [1:0]          wr_mode;
   logic                q_full;
   logic                q_push;
   cce_pkg::word_type   q_push_data;
   logic                q_pop;
   logic                q_valid;
   cce_pkg::word_type   q_data;

   // zero wait state register access
   assign csr_pready = 1'b1;

   // register file, seed writes reload the running crc
   cce_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg),
      .wr_mode     (wr_mode)
   );

   // front: accept and write-transpose each data word
   cce_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .wr_mode    (wr_mode),
      .q_full     (q_full),
      .push       (q_push),
      .push_data  (q_push_data)
   );

   // decoupling queue
   cce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_data  (q_data)
   );

   // back: crc rounds, final xor, read transpose, result register
   cce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/cce_checker.sv
// ----------------------------------------------------------------------------
// cce_checker
// port-level checks for the crc engine, bound to the top level
// ----------------------------------------------------------------------------
module cce_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [cce_pkg::WORD_W-1:0]  req_tdata,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [cce_pkg::WORD_W-1:0]  rsp_tdata,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [cce_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [cce_pkg::WORD_W-1:0]  csr_pwdata,
   input  logic [cce_pkg::WORD_W-1:0]  csr_prdata,
   input  logic                        csr_pready
);

   // no result can come out straight after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid ##1 !rsp_tvalid)
      else $error("result too soon after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // stalled input word holds until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("stalled input word changed");

   // register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready low");

   // polynomial register reads back what was written
   a_poly_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_paddr[4:2] == cce_pkg::REG_POLY)
      ##1 (csr_psel && !csr_pwrite && csr_paddr[4:2] == cce_pkg::REG_POLY)
      |-> csr_prdata == $past(csr_pwdata))
      else $error("polynomial readback mismatch");

endmodule

bind configurable_crc_engine_core cce_checker u_cce_checker (.*);
